### design/tlpt_pkg.sv
// ----------------------------------------------------------------------------
// tlpt_pkg
// Shared types and constants for the two-level page table manager.
// ----------------------------------------------------------------------------
package tlpt_pkg;

  localparam int unsigned IDX_W         = 10;
  localparam int unsigned OFF_W         = 12;
  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned DIR_COUNT     = 1024;

  localparam logic [IDX_W-1:0] ALIAS_DIR = 10'd768;
  localparam logic [20:0]      COUNT_MAX = 21'd1048576;
  localparam logic [20:0]      COUNT_RST = 21'd1024;
  localparam logic [OFF_W-1:0] IDENT_FLAGS = 12'h003;  // present + writable

  typedef enum logic [1:0] {
    OP_MAP   = 2'd0,
    OP_UNMAP = 2'd1,
    OP_XLATE = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SLOT    = 2'd1,
    ST_ALREADY    = 2'd2,
    ST_NOT_MAPPED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DIR,
    S_CLR,
    S_TRD,
    S_TAB,
    S_RESP
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] virt_addr;
    logic [19:0] phys_frame;
    logic [11:0] entry_flags;
  } req_word_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] xlate_addr;
    logic [20:0] mapped_count;
  } rsp_word_t;

endpackage

### design/tlpt_ram.sv
// ----------------------------------------------------------------------------
// tlpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlpt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/tlpt_resp.sv
// ----------------------------------------------------------------------------
// tlpt_resp
// Output register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module tlpt_resp (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  tlpt_pkg::rsp_word_t word,
  output logic                free,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output tlpt_pkg::rsp_word_t rsp
);

  assign free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= word;
    end
  end

endmodule

### design/two_level_page_table_manager_unit.sv
// ----------------------------------------------------------------------------
// two_level_page_table_manager_unit
// Sequence: an accepted request passes S_DIR (directory read), S_TAB (the
//   dependent table read) and S_RESP; S_TAB is skipped when the directory
//   entry is absent, no slot is left or the op is idle. A new request is
//   taken only in S_IDLE, once S_RESP has loaded the output register.
//   A map that allocates a new table first sweeps the slot to zero.
// Reset: an init sweep rebuilds the directory (entries 0 and 768
//   -> slot 0) and the slot 0 identity map; req_ready stays low meanwhile.
// ----------------------------------------------------------------------------
module two_level_page_table_manager_unit #(
  parameter int unsigned TABLE_SLOTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  tlpt_pkg::req_word_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output tlpt_pkg::rsp_word_t rsp
);

  localparam int unsigned IDX_W   = tlpt_pkg::IDX_W;
  localparam int unsigned SLOT_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned NF_W    = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned DIR_DW  = SLOT_W + 1;              // {present, slot}
  localparam int unsigned TAB_DEP = TABLE_SLOTS * tlpt_pkg::TABLE_ENTRIES;
  localparam int unsigned TAB_AW  = $clog2(TAB_DEP);

  // Sequencer state
  tlpt_pkg::state_t    state, state_next;
  logic [IDX_W-1:0]    sweep_cnt, sweep_cnt_next;   // init and slot-clear sweeps
  tlpt_pkg::req_word_t req_r, req_r_next;
  logic [SLOT_W-1:0]   slot_r, slot_r_next;
  logic [NF_W-1:0]     next_free, next_free_next;
  logic [20:0]         page_count, page_count_next;
  tlpt_pkg::rsp_word_t res, res_next;

  // Memory ports
  logic               dir_we;
  logic [IDX_W-1:0]   dir_waddr, dir_raddr;
  logic [DIR_DW-1:0]  dir_wdata, dir_rdata;
  logic               tab_we;
  logic [TAB_AW-1:0]  tab_waddr, tab_raddr;
  logic [31:0]        tab_wdata, tab_rdata;

  logic               rsp_free, rsp_load;

  logic [IDX_W-1:0]   didx, tidx;
  logic               dir_present;
  logic [SLOT_W-1:0]  dir_slot;
  logic [20:0]        count_inc, count_dec;

  assign didx        = req_r.virt_addr[31:22];
  assign tidx        = req_r.virt_addr[21:12];
  assign dir_present = dir_rdata[DIR_DW-1];
  assign dir_slot    = dir_rdata[SLOT_W-1:0];
  assign count_inc   = (page_count < tlpt_pkg::COUNT_MAX) ? page_count + 21'd1 : page_count;
  assign count_dec   = (page_count != 21'd0) ? page_count - 21'd1 : page_count;

  assign req_ready = (state == tlpt_pkg::S_IDLE);
  assign rsp_load  = (state == tlpt_pkg::S_RESP) && rsp_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tlpt_pkg::S_INIT;
      sweep_cnt  <= '0;
      next_free  <= NF_W'(1);
      page_count <= tlpt_pkg::COUNT_RST;
    end else begin
      state      <= state_next;
      sweep_cnt  <= sweep_cnt_next;
      next_free  <= next_free_next;
      page_count <= page_count_next;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_r_next;
    slot_r <= slot_r_next;
    res    <= res_next;
  end

  always_comb begin
    state_next      = state;
    sweep_cnt_next  = sweep_cnt;
    req_r_next      = req_r;
    slot_r_next     = slot_r;
    next_free_next  = next_free;
    page_count_next = page_count;
    res_next        = res;

    dir_we    = 1'b0;
    dir_waddr = didx;
    dir_wdata = {1'b1, next_free[SLOT_W-1:0]};
    dir_raddr = req.virt_addr[31:22];
    tab_we    = 1'b0;
    tab_waddr = TAB_AW'({slot_r, tidx});
    tab_wdata = '0;
    tab_raddr = TAB_AW'({slot_r, tidx});

    case (state)
      tlpt_pkg::S_INIT: begin
        // rebuild reset contents: both directory aliases -> slot 0,
        // slot 0 entry i = (i << 12) | present | writable
        dir_we    = 1'b1;
        dir_waddr = sweep_cnt;
        dir_wdata = (sweep_cnt == '0 || sweep_cnt == tlpt_pkg::ALIAS_DIR) ?
                    {1'b1, {SLOT_W{1'b0}}} : '0;
        tab_we    = 1'b1;
        tab_waddr = TAB_AW'(sweep_cnt);
        tab_wdata = {10'd0, sweep_cnt, tlpt_pkg::IDENT_FLAGS};
        sweep_cnt_next = sweep_cnt + 1'b1;
        if (sweep_cnt == '1) begin
          state_next = tlpt_pkg::S_IDLE;
        end
      end

      tlpt_pkg::S_IDLE: begin
        if (req_valid) begin
          req_r_next = req;
          state_next = tlpt_pkg::S_DIR;
        end
      end

      tlpt_pkg::S_DIR: begin
        res_next = '{status: tlpt_pkg::ST_OK, xlate_addr: 32'd0,
                     mapped_count: page_count};
        tab_raddr = TAB_AW'({dir_slot, tidx});
        slot_r_next = dir_slot;
        case (req_r.op)
          tlpt_pkg::OP_MAP: begin
            if (dir_present) begin
              state_next = tlpt_pkg::S_TAB;
            end else if (next_free >= NF_W'(TABLE_SLOTS)) begin
              res_next.status = tlpt_pkg::ST_NO_SLOT;
              state_next      = tlpt_pkg::S_RESP;
            end else begin
              // allocate the next slot; it is swept to zero before use
              dir_we         = 1'b1;
              slot_r_next    = next_free[SLOT_W-1:0];
              next_free_next = next_free + 1'b1;
              sweep_cnt_next = '0;
              state_next     = tlpt_pkg::S_CLR;
            end
          end
          tlpt_pkg::OP_UNMAP, tlpt_pkg::OP_XLATE: begin
            if (dir_present) begin
              state_next = tlpt_pkg::S_TAB;
            end else begin
              res_next.status = tlpt_pkg::ST_NOT_MAPPED;
              state_next      = tlpt_pkg::S_RESP;
            end
          end
          default: begin
            state_next = tlpt_pkg::S_RESP;
          end
        endcase
      end

      tlpt_pkg::S_CLR: begin
        tab_we         = 1'b1;
        tab_waddr      = TAB_AW'({slot_r, sweep_cnt});
        tab_wdata      = '0;
        sweep_cnt_next = sweep_cnt + 1'b1;
        if (sweep_cnt == '1) begin
          state_next = tlpt_pkg::S_TRD;
        end
      end

      tlpt_pkg::S_TRD: begin
        // table read issued at {slot_r, tidx} by default
        state_next = tlpt_pkg::S_TAB;
      end

      tlpt_pkg::S_TAB: begin
        state_next = tlpt_pkg::S_RESP;
        if (!tab_rdata[0]) begin
          if (req_r.op == tlpt_pkg::OP_MAP) begin
            tab_we                = 1'b1;
            tab_wdata             = {req_r.phys_frame, req_r.entry_flags};
            page_count_next       = count_inc;
            res_next.mapped_count = count_inc;
          end else begin
            res_next.status = tlpt_pkg::ST_NOT_MAPPED;
          end
        end else begin
          case (req_r.op)
            tlpt_pkg::OP_MAP: begin
              res_next.status = tlpt_pkg::ST_ALREADY;
            end
            tlpt_pkg::OP_UNMAP: begin
              tab_we                = 1'b1;
              tab_wdata             = '0;
              page_count_next       = count_dec;
              res_next.mapped_count = count_dec;
            end
            default: begin
              // frame base from the entry, offset from the address
              res_next.xlate_addr = {tab_rdata[31:12], req_r.virt_addr[11:0]};
            end
          endcase
        end
      end

      tlpt_pkg::S_RESP: begin
        if (rsp_free) begin
          state_next = tlpt_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = tlpt_pkg::S_IDLE;
      end
    endcase
  end

  // Directory: {present, slot} per directory index
  tlpt_ram #(
    .WIDTH (DIR_DW),
    .DEPTH (tlpt_pkg::DIR_COUNT)
  ) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  // Table store: slot-major, 1024 entries per slot
  tlpt_ram #(
    .WIDTH (32),
    .DEPTH (TAB_DEP)
  ) u_tab_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  tlpt_resp u_resp (
    .clk       (clk),
    .rst       (rst),
    .load      (rsp_load),
    .word      (res),
    .free      (rsp_free),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
